[sv/fpa_pkg.sv]
// shared types and constants of the q24.8 fixed-point alu
`default_nettype none
package fpa_pkg;
   localparam int FracBits  = 8;
   localparam int WordBits  = 32;
   localparam int SatBits   = (WordBits < 32) ? WordBits : 32;
   localparam int DataBits  = 32;
   localparam int NumBits   = DataBits + FracBits;
   localparam int WideBits  = 66;
   localparam int KindBits  = 4;

   typedef enum logic [KindBits-1:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_GT       = 4'd4,
      OP_LT       = 4'd5,
      OP_EQ       = 4'd6,
      OP_NE       = 4'd7,
      OP_MIN      = 4'd8,
      OP_MAX      = 4'd9,
      OP_INC      = 4'd10,
      OP_DEC      = 4'd11,
      OP_FROM_INT = 4'd12,
      OP_TO_INT   = 4'd13
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DIVZ = 2'd1,
      ST_SAT  = 2'd2
   } status_type;

   // one item as it travels down the cell row
   typedef struct packed {
      logic                       vld;
      logic [KindBits-1:0]        kind;
      logic                       q_neg;
      logic                       b_zero;
      logic                       sat_en;
      logic                       flag;
      logic signed [WideBits-1:0] res;
      logic [NumBits-1:0]         num;
      logic [DataBits-1:0]        rem;
      logic [NumBits-1:0]         quo;
      logic [DataBits-1:0]        den;
   } item_type;
endpackage
`default_nettype wire

[sv/fpa_prep.sv]
// operand decode, simple operations and the product of an incoming item
`default_nettype none
module fpa_prep
   import fpa_pkg::*;
(
   input  wire logic                       in_vld,
   input  wire logic [KindBits-1:0]        in_kind,
   input  wire logic signed [DataBits-1:0] in_a,
   input  wire logic signed [DataBits-1:0] in_b,
   output item_type                        out_item
);
   logic signed [WideBits-1:0] a_w;
   logic signed [WideBits-1:0] b_w;
   logic signed [63:0]         prod;
   logic [DataBits-1:0]        a_mag;
   logic [DataBits-1:0]        b_mag;

   assign a_w   = WideBits'(in_a);
   assign b_w   = WideBits'(in_b);
   assign prod  = 64'(in_a) * 64'(in_b);
   assign a_mag = in_a[DataBits-1] ? DataBits'(-in_a) : DataBits'(in_a);
   assign b_mag = in_b[DataBits-1] ? DataBits'(-in_b) : DataBits'(in_b);

   // per-opcode wide result ahead of rounding and clipping
   always_comb begin
      out_item        = '0;
      out_item.vld    = in_vld;
      out_item.kind   = in_kind;
      out_item.q_neg  = in_a[DataBits-1] ^ in_b[DataBits-1];
      out_item.b_zero = (in_b == '0);
      out_item.num    = {a_mag, {FracBits{1'b0}}};
      out_item.den    = b_mag;
      out_item.sat_en = 1'b1;
      case (opcode_type'(in_kind))
         OP_ADD:      out_item.res = a_w + b_w;
         OP_SUB:      out_item.res = a_w - b_w;
         OP_MUL:      out_item.res = WideBits'(prod);
         OP_DIV:      out_item.sat_en = 1'b1;
         OP_GT: begin
            out_item.flag = (in_a > in_b);
            out_item.sat_en = 1'b0;
         end
         OP_LT: begin
            out_item.flag = (in_a < in_b);
            out_item.sat_en = 1'b0;
         end
         OP_EQ: begin
            out_item.flag = (in_a == in_b);
            out_item.sat_en = 1'b0;
         end
         OP_NE: begin
            out_item.flag = (in_a != in_b);
            out_item.sat_en = 1'b0;
         end
         OP_MIN:      out_item.res = (in_a < in_b) ? a_w : b_w;
         OP_MAX:      out_item.res = (in_a > in_b) ? a_w : b_w;
         OP_INC:      out_item.res = a_w + WideBits'(1);
         OP_DEC:      out_item.res = a_w - WideBits'(1);
         OP_FROM_INT: out_item.res = a_w <<< FracBits;
         OP_TO_INT:   out_item.res = a_w >>> FracBits;
         default:     out_item.sat_en = 1'b0;
      endcase
   end
endmodule
`default_nettype wire

[sv/fpa_div_cell.sv]
// one restoring division step: one quotient bit per cell
`default_nettype none
module fpa_div_cell
   import fpa_pkg::*;
(
   input  item_type in_item,
   output item_type out_item
);
   logic [DataBits:0] rem_sh;
   logic [DataBits:0] diff;

   assign rem_sh = {in_item.rem, in_item.num[NumBits-1]};
   assign diff   = rem_sh - {1'b0, in_item.den};

   // trial subtract, keep it when it does not go negative
   always_comb begin
      out_item     = in_item;
      out_item.num = {in_item.num[NumBits-2:0], 1'b0};
      if (!diff[DataBits]) begin
         out_item.rem = diff[DataBits-1:0];
         out_item.quo = {in_item.quo[NumBits-2:0], 1'b1};
      end else begin
         out_item.rem = rem_sh[DataBits-1:0];
         out_item.quo = {in_item.quo[NumBits-2:0], 1'b0};
      end
   end
endmodule
`default_nettype wire

[sv/fpa_finish.sv]
// rounding of products and quotients, clipping and status
`default_nettype none
module fpa_finish
   import fpa_pkg::*;
(
   input  item_type                   in_item,
   output logic signed [DataBits-1:0] out_result,
   output logic                       out_flag,
   output logic [1:0]                 out_status
);
   localparam logic [63:0] Half = 64'((64'd1 << FracBits) >> 1);
   localparam logic signed [WideBits-1:0] SatHi =
      WideBits'((66'sd1 <<< (SatBits - 1)) - 66'sd1);
   localparam logic signed [WideBits-1:0] SatLo = -SatHi - WideBits'(1);

   logic [63:0]                p_mag;
   logic [64:0]                p_rnd;
   logic [NumBits:0]           q_rnd;
   logic                       round_up;
   logic signed [WideBits-1:0] val;

   assign p_mag    = in_item.res[63] ? 64'(-in_item.res) : in_item.res[63:0];
   assign p_rnd    = ({1'b0, p_mag} + {1'b0, Half}) >> FracBits;
   assign round_up = ({in_item.rem, 1'b0} >= {1'b0, in_item.den});
   assign q_rnd    = {1'b0, in_item.quo} + (NumBits+1)'(round_up);

   // select the unclipped value
   always_comb begin
      case (in_item.kind)
         OP_MUL:  val = in_item.res[63] ? -WideBits'(p_rnd) : WideBits'(p_rnd);
         OP_DIV:  val = in_item.q_neg ? -WideBits'(q_rnd) : WideBits'(q_rnd);
         default: val = in_item.res;
      endcase
   end

   // clip into the result word
   always_comb begin
      out_flag   = in_item.flag;
      out_status = ST_OK;
      out_result = '0;
      if (in_item.kind == OP_DIV && in_item.b_zero) begin
         out_status = ST_DIVZ;
      end else if (in_item.sat_en) begin
         if (val > SatHi) begin
            out_result = DataBits'(SatHi);
            out_status = ST_SAT;
         end else if (val < SatLo) begin
            out_result = DataBits'(SatLo);
            out_status = ST_SAT;
         end else begin
            out_result = DataBits'(val);
         end
      end
   end
endmodule
`default_nettype wire

[sv/fixed_point_q24_8_alu_unit.sv]
// top level of the signed q24.8 fixed-point alu
// usage:
//   req channel: tuser carries the opcode, tdata carries operand a in bits
//   31:0 and operand b in bits 63:32, both raw two's complement q24.8.
//   rsp channel: tdata carries the raw result, tuser carries the compare
//   flag (bit 0) and status (bits 2:1: ok, division by zero, saturated).
//   every item gives exactly one result item, in order.
// path: one decode/multiply stage, one cell per quotient bit of the 40-bit
//   dividend, one output register.
// throughput: one item per cycle while the output does not stall; the row of
//   division cells sets the latency and every cell takes a new item each cycle that the row moves.
// stall: when a result waits and rsp_tready is low, the whole row holds
//   and req_tready drops in the same cycle; nothing is lost or repeated.
// reset: synchronous, clears all stage valid bits and the output valid bit; the
//   data fields are not cleared and the block needs no warm-up.
`default_nettype none
module fixed_point_q24_8_alu_unit
   import fpa_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [63:0]         req_tdata,  // operand_a[31:0], operand_b[63:32]
   input  wire logic [KindBits-1:0] req_tuser,  // kind[3:0]
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [31:0]              rsp_tdata,  // result_raw[31:0]
   output logic [2:0]               rsp_tuser   // flag[0], status[2:1]
);
   localparam int Cells = NumBits;

   logic                       advance;
   item_type                   prep_item;
   item_type                   stage_ff [Cells+1];
   item_type                   stage_in [Cells+1];
   logic signed [DataBits-1:0] fin_result;
   logic                       fin_flag;
   logic [1:0]                 fin_status;
   logic                       out_vld_ff;
   logic [DataBits-1:0]        out_res_ff;
   logic                       out_flag_ff;
   logic [1:0]                 out_st_ff;

   // the row moves whenever the output register can take an item
   assign advance    = !out_vld_ff || rsp_tready;
   assign req_tready = advance;

   fpa_prep u_prep (
      .in_vld   (req_tvalid),
      .in_kind  (req_tuser),
      .in_a     (req_tdata[31:0]),
      .in_b     (req_tdata[63:32]),
      .out_item (prep_item)
   );

   assign stage_in[0] = prep_item;

   // row of division cells
   for (genvar i = 0; i < Cells; i++) begin : g_cell
      fpa_div_cell u_cell (
         .in_item  (stage_ff[i]),
         .out_item (stage_in[i+1])
      );
   end

   // stage registers between the cells
   for (genvar i = 0; i <= Cells; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[i].vld <= 1'b0;
         end else if (advance) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   fpa_finish u_finish (
      .in_item    (stage_ff[Cells]),
      .out_result (fin_result),
      .out_flag   (fin_flag),
      .out_status (fin_status)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff  <= stage_ff[Cells].vld;
         out_res_ff  <= fin_result;
         out_flag_ff <= fin_flag;
         out_st_ff   <= fin_status;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_res_ff;
   assign rsp_tuser  = {out_st_ff, out_flag_ff};

   // checks
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2:1] == ST_DIVZ) |-> (rsp_tdata == '0 && !rsp_tuser[0]))
      else $error("division by zero with nonzero result");
   a_flag_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tuser[2:1] == ST_OK && rsp_tdata == '0))
      else $error("compare flag with nonzero result or status");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output stall");
endmodule
`default_nettype wire

[test/fixed_point_q24_8_alu_unit_test.sv]
// self-checking testbench of the q24.8 fixed-point alu
`default_nettype none
module fixed_point_q24_8_alu_unit_test;
   import fpa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] a;
      logic [31:0] b;
   } alu_op_type;

   typedef struct packed {
      logic [31:0] res;
      logic        flag;
      logic [1:0]  status;
   } alu_res_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   alu_op_type  pending_ops[$];
   alu_res_type expected_results[$];
   int          send_idle_pct = 15;
   int          recv_idle_pct = 78;
   int          mismatch_count = 0;
   bit          hold_sender = 1'b0;

   fixed_point_q24_8_alu_unit uut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // saturate into the signed 32-bit word
   function automatic logic signed [63:0] clip_word(input logic signed [63:0] v,
                                                    inout logic [1:0] st);
      if (v > 64'sd2147483647) begin
         st = ST_SAT;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         st = ST_SAT;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic alu_res_type alu_predict(input alu_op_type op);
      logic signed [63:0] a, b, r, p;
      logic [63:0] n, d, q, m;
      logic [1:0] st;
      logic fl;
      bit clipped;
      alu_res_type o;
      a = {{32{op.a[31]}}, op.a};
      b = {{32{op.b[31]}}, op.b};
      r = 0;
      st = ST_OK;
      fl = 1'b0;
      clipped = 1'b1;
      case (op.kind)
         OP_ADD: r = a + b;
         OP_SUB: r = a - b;
         OP_MUL: begin
            // round half away from zero on the magnitude
            p = a * b;
            m = (p < 0) ? -p : p;
            q = (m + 64'd128) >> FracBits;
            r = (p < 0) ? -$signed(q) : $signed(q);
         end
         OP_DIV: begin
            if (b == 0) begin
               st = ST_DIVZ;
               clipped = 1'b0;
            end else begin
               n = ((a < 0) ? -a : a) << FracBits;
               d = (b < 0) ? -b : b;
               q = n / d;
               if ((n % d) * 2 >= d) q = q + 1;
               r = ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
            end
         end
         OP_GT: begin fl = a > b;  clipped = 1'b0; end
         OP_LT: begin fl = a < b;  clipped = 1'b0; end
         OP_EQ: begin fl = a == b; clipped = 1'b0; end
         OP_NE: begin fl = a != b; clipped = 1'b0; end
         OP_MIN: r = (a < b) ? a : b;
         OP_MAX: r = (a > b) ? a : b;
         OP_INC: r = a + 1;
         OP_DEC: r = a - 1;
         OP_FROM_INT: r = a * 256;
         OP_TO_INT: r = a >>> FracBits;
         default: clipped = 1'b0;
      endcase
      if (clipped) r = clip_word(r, st);
      o.res = r[31:0];
      o.flag = fl;
      o.status = st;
      return o;
   endfunction

   // operand with bias toward edges
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($urandom_range(0, 3)) - 32'd1;
         3: return 32'($signed($urandom_range(0, 4096)) - 2048);
         4: return {{16{1'b0}}, 16'($urandom)};
         5: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return $urandom;
      endcase
   endfunction

   task automatic add_op(input logic [3:0] k, input logic [31:0] a,
                         input logic [31:0] b);
      alu_op_type op;
      op.kind = k;
      op.a = a;
      op.b = b;
      pending_ops.push_back(op);
   endtask

   task automatic add_random(input int count);
      repeat (count) begin
         add_op(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
      end
   endtask

   // driver
   always @(posedge clock) begin
      alu_op_type op;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_ops.size() > 0 && !hold_sender &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            op = pending_ops.pop_front();
            expected_results.push_back(alu_predict(op));
            req_tvalid <= 1'b1;
            req_tuser <= op.kind;
            req_tdata <= {op.b, op.a};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      alu_res_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected result item %h", rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata !== want.res || rsp_tuser[0] !== want.flag ||
                   rsp_tuser[2:1] !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: want res %h flag %b st %0d, got res %h flag %b st %0d",
                              want.res, want.flag, want.status,
                              rsp_tdata, rsp_tuser[0], rsp_tuser[2:1]);
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // stimulus and phases
   initial begin
      logic [3:0] k;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: every opcode at the extremes
      for (int i = 0; i < 16; i++) begin
         k = 4'(i);
         add_op(k, 32'h7fffffff, 32'h7fffffff);
      end
      add_op(OP_ADD, 32'h80000000, 32'h80000000);
      add_op(OP_SUB, 32'h80000000, 32'h00000001);
      add_op(OP_DIV, 32'h00000100, 32'h0);
      add_op(OP_DIV, 32'h80000000, 32'hffffffff);
      add_op(OP_MUL, 32'h00000180, 32'hffffff80);
      add_op(OP_INC, 32'h7fffffff, 32'h0);
      add_op(OP_DEC, 32'h80000000, 32'h0);
      add_op(OP_TO_INT, 32'hffffff01, 32'hffffffff);
      add_op(OP_FROM_INT, 32'h00800000, 32'hffffffff);
      add_random(350);
      wait (pending_ops.size() == 0);
      // hold off until everything drained
      hold_sender = 1'b1;
      wait (expected_results.size() == 0);
      hold_sender = 1'b0;
      send_idle_pct = 78;
      recv_idle_pct = 15;
      add_random(350);
      wait (pending_ops.size() == 0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random(375);
      wait (pending_ops.size() == 0);
      wait (expected_results.size() == 0);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
